@@ sv/small_language_lexer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Lexer assertion macros
// Shared property wrappers for the lexer checks.
// ----------------------------------------------------------------------------
`ifndef SMALL_LANGUAGE_LEXER_UNIT_DEFINES_SVH
`define SMALL_LANGUAGE_LEXER_UNIT_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle
`define SLL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define SLL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sll_pkg.sv @@
// ----------------------------------------------------------------------------
// Lexer package
// Types, token kinds, lexer states and the keyword table.
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int unsigned LengthLimitDefault  = 255;
  localparam int unsigned KeywordCountDefault = 10;
  localparam int unsigned KwTable             = 10;
  localparam int unsigned KwMaxLen            = 5;

  typedef enum logic [4:0] {
    TK_IDENT    = 5'd0,
    TK_KEYWORD  = 5'd1,
    TK_INT      = 5'd2,
    TK_FLOAT    = 5'd3,
    TK_CHAR     = 5'd4,
    TK_COMMA    = 5'd5,
    TK_SEMI     = 5'd6,
    TK_LPAREN   = 5'd7,
    TK_RPAREN   = 5'd8,
    TK_LBRACE   = 5'd9,
    TK_RBRACE   = 5'd10,
    TK_LT       = 5'd11,
    TK_GT       = 5'd12,
    TK_PLUS     = 5'd13,
    TK_MINUS    = 5'd14,
    TK_STAR     = 5'd15,
    TK_SLASH    = 5'd16,
    TK_ASSIGN   = 5'd17,
    TK_EQ       = 5'd18,
    TK_ERR_NUM  = 5'd19,
    TK_ERR_CHAR = 5'd20,
    TK_ERR_QUOT = 5'd21,
    TK_ERR_PCT  = 5'd22,
    TK_ERR_CMT  = 5'd23,
    TK_END      = 5'd24
  } tok_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_IDENT  = 4'd1,
    ST_INT    = 4'd2,
    ST_FRAC   = 4'd3,
    ST_BADINT = 4'd4,
    ST_BADFLT = 4'd5,
    ST_EQ     = 4'd6,
    ST_Q1     = 4'd7,
    ST_Q2     = 4'd8,
    ST_PCT    = 4'd9,
    ST_LINE   = 4'd10,
    ST_SLASH  = 4'd11,
    ST_BLOCK  = 4'd12,
    ST_BSTAR  = 4'd13
  } lex_state_e;

  // One token as it travels to the output stage
  typedef struct packed {
    tok_kind_e   kind;
    logic [3:0]  kw_idx;
    logic [7:0]  len;
    logic [7:0]  cval;
    logic        is_err;
    logic        last;
  } tok_t;

  // Per-item work produced by the front end
  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
    logic       clr;
  } fq_item_t;

  function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned p);
    logic [7:0] r;
    r = 8'd0;
    case (k)
      0: case (p) 0: r = "i"; 1: r = "n"; 2: r = "t"; default: r = 8'd0; endcase
      1: case (p) 0: r = "c"; 1: r = "h"; 2: r = "a"; 3: r = "r"; default: r = 8'd0; endcase
      2: case (p) 0: r = "b"; 1: r = "o"; 2: r = "o"; 3: r = "l"; default: r = 8'd0; endcase
      3: case (p) 0: r = "i"; 1: r = "f"; default: r = 8'd0; endcase
      4: case (p) 0: r = "t"; 1: r = "h"; 2: r = "e"; 3: r = "n"; default: r = 8'd0; endcase
      5: case (p) 0: r = "e"; 1: r = "l"; 2: r = "s"; 3: r = "e"; default: r = 8'd0; endcase
      6: case (p)
           0: r = "w"; 1: r = "h"; 2: r = "i"; 3: r = "l"; 4: r = "e";
           default: r = 8'd0;
         endcase
      7: case (p) 0: r = "d"; 1: r = "o"; default: r = 8'd0; endcase
      8: case (p) 0: r = "t"; 1: r = "r"; 2: r = "u"; 3: r = "e"; default: r = 8'd0; endcase
      9: case (p)
           0: r = "f"; 1: r = "a"; 2: r = "l"; 3: r = "s"; 4: r = "e";
           default: r = 8'd0;
         endcase
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kw_len(input int unsigned k);
    logic [2:0] r;
    case (k)
      0: r = 3'd3; 1: r = 3'd4; 2: r = 3'd4; 3: r = 3'd2; 4: r = 3'd4;
      5: r = 3'd4; 6: r = 3'd5; 7: r = 3'd2; 8: r = 3'd4; 9: r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/sll_stream_if.sv @@
// ----------------------------------------------------------------------------
// Lexer stream interfaces
// Valid/ready channels for characters in and tokens out.
// ----------------------------------------------------------------------------
interface sll_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;
  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

interface sll_tok_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [3:0]  keyword_index;
  logic [7:0]  token_length;
  logic [7:0]  char_value;
  logic [15:0] error_count;
  logic        last;
  modport source (output valid, output token_kind, output keyword_index,
                  output token_length, output char_value, output error_count,
                  output last, input ready);
  modport sink   (input valid, input token_kind, input keyword_index,
                  input token_length, input char_value, input error_count,
                  input last, output ready);
endinterface

@@ sv/sll_front.sv @@
// ----------------------------------------------------------------------------
// Lexer front end
// Runs the scanner state machine once per character and packs its tokens for the queue.
// ----------------------------------------------------------------------------
module sll_front
  import sll_pkg::*;
#(
  parameter int unsigned LengthLimit  = LengthLimitDefault,
  parameter int unsigned KeywordCount = KeywordCountDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] char_i,
  input  logic       eot_i,
  output fq_item_t   item_o
);

  localparam logic [7:0] LenCap = (LengthLimit < 255) ? LengthLimit[7:0] : 8'd255;

  lex_state_e  state_q, state_d;
  logic [7:0]  len_q, len_d;
  logic [KwTable-1:0] mask_q, mask_d;
  logic [7:0]  held_q, held_d;

  logic is_alpha, is_digit;
  assign is_alpha = ((char_i >= "a") && (char_i <= "z")) || ((char_i >= "A") && (char_i <= "Z"));
  assign is_digit = (char_i >= "0") && (char_i <= "9");

  // Clocked scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= 8'd0;
      mask_q  <= '1;
      held_q  <= 8'd0;
    end else if (fire_i) begin
      state_q <= state_d;
      len_q   <= len_d;
      mask_q  <= mask_d;
      held_q  <= held_d;
    end
  end

  function automatic tok_t mk(input tok_kind_e k, input logic [3:0] kw,
                              input logic [7:0] l, input logic [7:0] cv);
    tok_t t;
    t.kind   = k;
    t.kw_idx = kw;
    t.len    = l;
    t.cval   = cv;
    t.is_err = (k == TK_ERR_NUM) || (k == TK_ERR_CHAR) || (k == TK_ERR_QUOT) ||
               (k == TK_ERR_PCT) || (k == TK_ERR_CMT);
    t.last   = 1'b0;
    return t;
  endfunction

  // Next state and tokens for one character
  always_comb begin
    tok_t       pend;
    logic       has_pend;
    logic       restart;
    tok_t       st;
    logic       has_st;
    logic [3:0] idx;
    logic [KwTable-1:0] m;
    logic [7:0] lg;

    state_d = state_q;
    len_d   = len_q;
    mask_d  = mask_q;
    held_d  = held_q;
    pend    = mk(TK_IDENT, 4'd0, 8'd0, 8'd0);
    has_pend = 1'b0;
    restart = 1'b0;
    st      = mk(TK_IDENT, 4'd0, 8'd0, 8'd0);
    has_st  = 1'b0;
    lg      = (len_q < LenCap) ? len_q + 8'd1 : len_q;

    // Keyword match at the end of the identifier
    idx = 4'd0;
    for (int unsigned k = 0; k < KwTable; k++) begin
      if (k < KeywordCount && mask_q[k] && ({5'd0, kw_len(k)} == len_q))
        idx = 4'(k + 1);
    end

    // Keyword mask update for an identifier character at position len_q
    m = mask_q;
    for (int unsigned k = 0; k < KwTable; k++) begin
      if ((len_q >= {5'd0, kw_len(k)}) || (kw_char(k, 32'(len_q[2:0])) != char_i))
        m[k] = 1'b0;
    end

    item_o.clr = 1'b0;
    if (eot_i) begin
      // Flush pending token then summarize
      case (state_q)
        ST_IDENT:  begin has_pend = 1'b1;
                     pend = mk((idx != 0) ? TK_KEYWORD : TK_IDENT, idx, len_q, 8'd0); end
        ST_INT:    begin has_pend = 1'b1; pend = mk(TK_INT, 4'd0, len_q, 8'd0); end
        ST_FRAC:   begin has_pend = 1'b1; pend = mk(TK_FLOAT, 4'd0, len_q, 8'd0); end
        ST_BADINT, ST_BADFLT: begin
                     has_pend = 1'b1; pend = mk(TK_ERR_NUM, 4'd0, len_q, 8'd0); end
        ST_EQ:     begin has_pend = 1'b1; pend = mk(TK_ASSIGN, 4'd0, 8'd1, 8'd0); end
        ST_Q1, ST_Q2: begin
                     has_pend = 1'b1; pend = mk(TK_ERR_QUOT, 4'd0, len_q, 8'd0); end
        ST_PCT:    begin has_pend = 1'b1; pend = mk(TK_ERR_PCT, 4'd0, 8'd1, 8'd0); end
        ST_SLASH:  begin has_pend = 1'b1; pend = mk(TK_SLASH, 4'd0, 8'd1, 8'd0); end
        ST_BLOCK, ST_BSTAR: begin
                     has_pend = 1'b1; pend = mk(TK_ERR_CMT, 4'd0, 8'd2, 8'd0); end
        default: ;
      endcase
      has_st     = 1'b1;
      st         = mk(TK_END, 4'd0, 8'd0, 8'd0);
      item_o.clr = 1'b1;
      state_d = ST_IDLE;
      len_d   = 8'd0;
      mask_d  = '1;
      held_d  = 8'd0;
    end else begin
      case (state_q)
        ST_IDENT: begin
          if (is_alpha || is_digit) begin
            mask_d = m;
            len_d  = lg;
          end else begin
            has_pend = 1'b1;
            pend = mk((idx != 0) ? TK_KEYWORD : TK_IDENT, idx, len_q, 8'd0);
            restart = 1'b1;
          end
        end
        ST_INT: begin
          if (is_digit) len_d = lg;
          else if (char_i == ".") begin len_d = lg; state_d = ST_FRAC; end
          else if (is_alpha) begin len_d = lg; state_d = ST_BADINT; end
          else begin
            has_pend = 1'b1; pend = mk(TK_INT, 4'd0, len_q, 8'd0); restart = 1'b1;
          end
        end
        ST_FRAC: begin
          if (is_digit) len_d = lg;
          else if (char_i == "." || is_alpha) begin len_d = lg; state_d = ST_BADFLT; end
          else begin
            has_pend = 1'b1; pend = mk(TK_FLOAT, 4'd0, len_q, 8'd0); restart = 1'b1;
          end
        end
        ST_BADINT: begin
          if (is_alpha || is_digit) len_d = lg;
          else begin
            has_pend = 1'b1; pend = mk(TK_ERR_NUM, 4'd0, len_q, 8'd0); restart = 1'b1;
          end
        end
        ST_BADFLT: begin
          if (is_alpha || char_i == ".") len_d = lg;
          else begin
            has_pend = 1'b1; pend = mk(TK_ERR_NUM, 4'd0, len_q, 8'd0); restart = 1'b1;
          end
        end
        ST_EQ: begin
          if (char_i == "=") begin
            has_pend = 1'b1; pend = mk(TK_EQ, 4'd0, 8'd2, 8'd0); state_d = ST_IDLE;
          end else begin
            has_pend = 1'b1; pend = mk(TK_ASSIGN, 4'd0, 8'd1, 8'd0); restart = 1'b1;
          end
        end
        ST_Q1: begin
          held_d = char_i; len_d = lg; state_d = ST_Q2;
        end
        ST_Q2: begin
          len_d = lg;
          has_pend = 1'b1;
          if (char_i == "'") pend = mk(TK_CHAR, 4'd0, lg, held_q);
          else pend = mk(TK_ERR_QUOT, 4'd0, lg, 8'd0);
          state_d = ST_IDLE;
        end
        ST_PCT: begin
          if (char_i == "%") state_d = ST_LINE;
          else begin
            has_pend = 1'b1; pend = mk(TK_ERR_PCT, 4'd0, 8'd1, 8'd0); restart = 1'b1;
          end
        end
        ST_LINE:  if (char_i == 8'h0A) state_d = ST_IDLE;
        ST_SLASH: begin
          if (char_i == "*") state_d = ST_BLOCK;
          else begin
            has_pend = 1'b1; pend = mk(TK_SLASH, 4'd0, 8'd1, 8'd0); restart = 1'b1;
          end
        end
        ST_BLOCK: if (char_i == "*") state_d = ST_BSTAR;
        ST_BSTAR: begin
          if (char_i == "/") state_d = ST_IDLE;
          else if (char_i != "*") state_d = ST_BLOCK;
        end
        default: restart = 1'b1;
      endcase

      // Lex the character afresh from idle
      if (restart) begin
        len_d   = 8'd0;
        mask_d  = '1;
        held_d  = 8'd0;
        state_d = ST_IDLE;
        if (is_alpha) begin
          state_d = ST_IDENT;
          for (int unsigned k = 0; k < KwTable; k++) begin
            if (kw_char(k, 0) != char_i) mask_d[k] = 1'b0;
          end
          len_d = 8'd1;
        end else if (is_digit) begin
          state_d = ST_INT; len_d = 8'd1;
        end else begin
          case (char_i)
            "=":  begin state_d = ST_EQ; len_d = 8'd1; end
            "'":  begin state_d = ST_Q1; len_d = 8'd1; end
            "%":  state_d = ST_PCT;
            "/":  state_d = ST_SLASH;
            " ", 8'h09, 8'h0A: ;
            ",":  begin has_st = 1'b1; st = mk(TK_COMMA,  4'd0, 8'd1, 8'd0); end
            ";":  begin has_st = 1'b1; st = mk(TK_SEMI,   4'd0, 8'd1, 8'd0); end
            "(":  begin has_st = 1'b1; st = mk(TK_LPAREN, 4'd0, 8'd1, 8'd0); end
            ")":  begin has_st = 1'b1; st = mk(TK_RPAREN, 4'd0, 8'd1, 8'd0); end
            "{":  begin has_st = 1'b1; st = mk(TK_LBRACE, 4'd0, 8'd1, 8'd0); end
            "}":  begin has_st = 1'b1; st = mk(TK_RBRACE, 4'd0, 8'd1, 8'd0); end
            "<":  begin has_st = 1'b1; st = mk(TK_LT,     4'd0, 8'd1, 8'd0); end
            ">":  begin has_st = 1'b1; st = mk(TK_GT,     4'd0, 8'd1, 8'd0); end
            "+":  begin has_st = 1'b1; st = mk(TK_PLUS,   4'd0, 8'd1, 8'd0); end
            "-":  begin has_st = 1'b1; st = mk(TK_MINUS,  4'd0, 8'd1, 8'd0); end
            "*":  begin has_st = 1'b1; st = mk(TK_STAR,   4'd0, 8'd1, 8'd0); end
            default: begin has_st = 1'b1; st = mk(TK_ERR_CHAR, 4'd0, 8'd1, 8'd0); end
          endcase
        end
      end
    end

    // Pack tokens in order, mark the final one
    item_o.n  = {1'b0, has_pend} + {1'b0, has_st};
    item_o.t0 = has_pend ? pend : st;
    item_o.t1 = st;
    if (has_pend && has_st) item_o.t1.last = 1'b1;
    else item_o.t0.last = 1'b1;
  end

endmodule

@@ sv/sll_queue.sv @@
// ----------------------------------------------------------------------------
// Lexer token queue
// Small FIFO of per-character work between front and back end.
// ----------------------------------------------------------------------------
module sll_queue
  import sll_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  fq_item_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output fq_item_t data_o
);

  fq_item_t   mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];
  assign cnt_d   = cnt_q + {1'b0, push_i} - {1'b0, pop_i};

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
    end
  end

endmodule

@@ sv/sll_back.sv @@
// ----------------------------------------------------------------------------
// Lexer back end
// Sends queued tokens one per cycle unless stalled and keeps the error count.
// ----------------------------------------------------------------------------
module sll_back
  import sll_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  fq_item_t item_i,
  output logic     pop_o,
  sll_tok_if.source tok_o
);

  logic        sel_q;
  logic [15:0] err_q;
  tok_t        cur;
  logic [15:0] err_new;
  logic        out_v_q;
  tok_t        out_q;
  logic [15:0] out_err_q;
  logic        take;
  logic        done_item;

  assign cur       = sel_q ? item_i.t1 : item_i.t0;
  assign err_new   = (cur.is_err && err_q != 16'hFFFF) ? err_q + 16'd1 : err_q;
  assign take      = !empty_i && (!out_v_q || tok_o.ready);
  assign done_item = sel_q || (item_i.n != 2'd2);
  assign pop_o     = take && done_item;

  // Output register and error counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= 1'b0;
      err_q   <= 16'd0;
      out_v_q <= 1'b0;
    end else begin
      if (tok_o.ready) out_v_q <= 1'b0;
      if (take) begin
        out_v_q <= 1'b1;
        sel_q   <= !done_item;
        err_q   <= (item_i.clr && cur.last) ? 16'd0 : err_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q     <= cur;
      out_err_q <= err_new;
    end
  end

  assign tok_o.valid         = out_v_q;
  assign tok_o.token_kind    = out_q.kind;
  assign tok_o.keyword_index = out_q.kw_idx;
  assign tok_o.token_length  = out_q.len;
  assign tok_o.char_value    = out_q.cval;
  assign tok_o.error_count   = out_err_q;
  assign tok_o.last          = out_q.last;

endmodule

@@ sv/small_language_lexer_unit.sv @@
// A token passes the queue and then the back end's output register on its way to the port.
// Throughput: one character per cycle while the queue is not full; the back end sends
// one token per cycle while the token port is ready, so a character giving two tokens
// sends them in turn. A two-entry queue between scanner and sender absorbs those bursts.
// Reset: asynchronous active low; scanner idle, error count zero, queue empty.
// ----------------------------------------------------------------------------
// Small language lexer
// Character-stream tokenizer with keyword match and error reporting.
// ----------------------------------------------------------------------------
`include "small_language_lexer_unit_defines.svh"
module small_language_lexer_unit
  import sll_pkg::*;
#(
  parameter int unsigned LengthLimit  = LengthLimitDefault,
  parameter int unsigned KeywordCount = KeywordCountDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  sll_char_if.sink  char_i,
  sll_tok_if.source tok_o
);

  fq_item_t fr_item, q_item;
  logic     q_full, q_empty, q_pop, fire;

  assign char_i.ready = !q_full;
  assign fire         = char_i.valid && !q_full;

  sll_front #(.LengthLimit(LengthLimit), .KeywordCount(KeywordCount)) u_front (
    .clk_i, .rst_ni, .fire_i(fire), .char_i(char_i.char_in),
    .eot_i(char_i.end_of_text), .item_o(fr_item)
  );

  sll_queue u_queue (
    .clk_i, .rst_ni, .push_i(fire && fr_item.n != 2'd0), .data_i(fr_item),
    .full_o(q_full), .pop_i(q_pop), .empty_o(q_empty), .data_o(q_item)
  );

  sll_back u_back (
    .clk_i, .rst_ni, .empty_i(q_empty), .item_i(q_item), .pop_o(q_pop), .tok_o(tok_o)
  );

  `SLL_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, q_pop, !q_empty, "pop from empty queue")
  `SLL_ASSERT_IMP(a_eot_queues, clk_i, rst_ni, fire && char_i.end_of_text,
    fr_item.n != 2'd0, "end of text produced no summary")
  `SLL_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, tok_o.valid && !tok_o.ready,
    tok_o.valid, "token dropped while stalled")

endmodule
